@@ sv/gccg_pkg.sv @@
`timescale 1ns / 1ps
package gccg_pkg;

    localparam int unsigned COV_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 17;
    localparam int unsigned CON_W     = 17;

    localparam logic [COV_W-1:0] COV_MAX   = 8'd255;
    // rounding offset: half of 255 * 65536
    localparam logic [30:0]      HALF_DEN  = 31'd8355840;
    // floor(x / 255) ~= (x * 257) >> 16, one short at most
    localparam logic [8:0]       RECIP_255 = 9'd257;

    localparam logic [CFG_IDX_W-1:0] CFG_LCD_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BGR_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_EN  = 2'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic             adv;
        logic             wr_en;
        logic [COV_W-1:0] wr_idx;
        logic [COV_W-1:0] wr_val;
        logic [CON_W-1:0] contrast;
        logic             gamma_en;
    } t_lane_ctl;

    typedef struct packed {
        logic adv;
        logic valid;
        logic lcd_mode;
        logic bgr_order;
    } t_merge_ctl;

endpackage

@@ sv/gccg_lane.sv @@
`timescale 1ns / 1ps
module gccg_lane import gccg_pkg::*; (
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  logic [COV_W-1:0] i_cov,
    output logic [COV_W-1:0] o_res
);

    logic [COV_W-1:0] r_gamma [256];

    logic [COV_W-1:0] r_v1;
    logic [13:0]      r_prod1;
    logic [COV_W-1:0] r_v2;
    logic [14:0]      r_x2;
    logic [COV_W-1:0] r_r3;
    logic             r_byp3;
    logic [COV_W-1:0] r_rd4;
    logic [COV_W-1:0] r_bv4;
    logic             r_byp4;

    logic [15:0]      n_full;
    logic [13:0]      n_prod1;
    logic [30:0]      n_sum2;
    logic [23:0]      n_recip;
    logic [COV_W-1:0] n_q0;
    logic [15:0]      n_rem;
    logic [COV_W-1:0] n_q;
    logic [8:0]       n_sum3;
    logic [COV_W-1:0] n_r3;
    logic             n_end;

    always_comb begin
        n_full  = 16'(COV_MAX - i_cov) * 16'(i_cov);
        n_prod1 = n_full[13:0];
        n_sum2  = 31'(r_prod1) * 31'(i_ctl.contrast) + HALF_DEN;
        // divide the upper part by 255 with one correction step
        n_recip = 24'(r_x2) * 24'(RECIP_255);
        n_q0    = n_recip[23:16];
        n_rem   = 16'(r_x2) - 16'(n_q0) * 16'(COV_MAX);
        n_q     = (n_rem >= 16'(COV_MAX)) ? n_q0 + 8'd1 : n_q0;
        n_sum3  = 9'(r_v2) + 9'(n_q);
        n_r3    = n_sum3[8] ? COV_MAX : n_sum3[7:0];
        n_end   = (r_v2 == 8'd0) || (r_v2 == COV_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_v1    <= i_cov;
            r_prod1 <= n_prod1;
            r_v2    <= r_v1;
            r_x2    <= n_sum2[30:16];
            r_r3    <= n_r3;
            r_byp3  <= n_end || !i_ctl.gamma_en;
            r_bv4   <= r_r3;
            r_byp4  <= r_byp3;
        end
    end

    // table write and lookup sit in the same stage, so loads and pixels keep order
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && i_ctl.wr_en) begin
            r_gamma[i_ctl.wr_idx] <= i_ctl.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_rd4 <= r_gamma[r_r3];
        end
    end

    assign o_res = r_byp4 ? r_bv4 : r_rd4;

endmodule

@@ sv/gccg_merge.sv @@
`timescale 1ns / 1ps
module gccg_merge import gccg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_merge_ctl         i_ctl,
    input  logic [COV_W-1:0]   i_res_first,
    input  logic [COV_W-1:0]   i_res_second,
    input  logic [COV_W-1:0]   i_res_third,
    output logic               o_valid,
    output logic [4*COV_W-1:0] o_data
);

    logic               r_valid;
    logic [4*COV_W-1:0] r_data;

    logic [COV_W-1:0]   n_r;
    logic [COV_W-1:0]   n_g;
    logic [COV_W-1:0]   n_b;
    logic [COV_W-1:0]   n_a;
    logic [4*COV_W-1:0] n_data;

    always_comb begin
        n_r = i_ctl.bgr_order ? i_res_third : i_res_first;
        n_g = i_res_second;
        n_b = i_ctl.bgr_order ? i_res_first : i_res_third;
        n_a = (n_r > n_g) ? n_r : n_g;
        n_a = (n_a > n_b) ? n_a : n_b;
        if (i_ctl.lcd_mode) begin
            n_data = {n_a, n_b, n_g, n_r};
        end else begin
            n_data = {24'd0, i_res_first};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/glyph_coverage_contrast_gamma.sv @@
`timescale 1ns / 1ps
// An accepted pixel request passes the 4 lane stages and the output register before o_m_tvalid.
// Throughput: one request per cycle; the whole pipeline holds only while the output register
// waits on i_m_tready. Table loads give no output.
// Reset: synchronous, active low; clears configuration and stage valid bits.
// The three gamma table copies are not cleared and hold garbage until loaded.
module glyph_coverage_contrast_gamma import gccg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [7:0] table_index, [15:8] table_value, [23:16] cov_first,
    // [31:24] cov_second, [39:32] cov_third
    input  logic [39:0]          i_s_tdata,
    // [0] action
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] res_first, [15:8] res_second, [23:16] res_third, [31:24] res_alpha
    output logic [31:0]          o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic             r_lcd_mode;
    logic             r_bgr_order;
    logic [CON_W-1:0] r_contrast;
    logic             r_gamma_en;

    logic [3:0]       r_vld;
    logic [3:0]       r_pix;
    logic [COV_W-1:0] r_idx [3];
    logic [COV_W-1:0] r_val [3];

    logic             w_adv;
    t_lane_ctl        w_lane_ctl;
    t_merge_ctl       w_merge_ctl;
    logic [COV_W-1:0] w_res [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcd_mode  <= 1'b0;
            r_bgr_order <= 1'b0;
            r_contrast  <= '0;
            r_gamma_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LCD_MODE:  r_lcd_mode  <= i_cfg_data[0];
                CFG_BGR_ORDER: r_bgr_order <= i_cfg_data[0];
                CFG_CONTRAST:  r_contrast  <= i_cfg_data;
                CFG_GAMMA_EN:  r_gamma_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pix    <= {r_pix[2:0], i_s_tuser == ACT_PIXEL};
            r_idx[0] <= i_s_tdata[7:0];
            r_val[0] <= i_s_tdata[15:8];
            r_idx[1] <= r_idx[0];
            r_val[1] <= r_val[0];
            r_idx[2] <= r_idx[1];
            r_val[2] <= r_val[1];
        end
    end

    always_comb begin
        w_lane_ctl.adv      = w_adv;
        w_lane_ctl.wr_en    = r_vld[2] && !r_pix[2];
        w_lane_ctl.wr_idx   = r_idx[2];
        w_lane_ctl.wr_val   = r_val[2];
        w_lane_ctl.contrast = r_contrast;
        w_lane_ctl.gamma_en = r_gamma_en;

        w_merge_ctl.adv       = w_adv;
        w_merge_ctl.valid     = r_vld[3] && r_pix[3];
        w_merge_ctl.lcd_mode  = r_lcd_mode;
        w_merge_ctl.bgr_order = r_bgr_order;
    end

    gccg_lane u_lane_first (
        .i_clk (i_clk),
        .i_ctl (w_lane_ctl),
        .i_cov (i_s_tdata[23:16]),
        .o_res (w_res[0])
    );

    gccg_lane u_lane_second (
        .i_clk (i_clk),
        .i_ctl (w_lane_ctl),
        .i_cov (i_s_tdata[31:24]),
        .o_res (w_res[1])
    );

    gccg_lane u_lane_third (
        .i_clk (i_clk),
        .i_ctl (w_lane_ctl),
        .i_cov (i_s_tdata[39:32]),
        .o_res (w_res[2])
    );

    gccg_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_merge_ctl),
        .i_res_first  (w_res[0]),
        .i_res_second (w_res[1]),
        .i_res_third  (w_res[2]),
        .o_valid      (o_m_tvalid),
        .o_data       (o_m_tdata)
    );

    // a table load leaving the last lane stage never shows up as a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !r_pix[3] && w_adv) |=> !o_m_tvalid)
        else $error("table load produced a result");

    // a pixel leaving the last lane stage always becomes a result
    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r_pix[3] && w_adv) |=> o_m_tvalid)
        else $error("pixel dropped at merge");

    // alpha is either zero (grey) or the largest channel
    a_alpha_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[31:24] == 8'd0) ||
                       ((o_m_tdata[31:24] >= o_m_tdata[7:0]) &&
                        (o_m_tdata[31:24] >= o_m_tdata[15:8]) &&
                        (o_m_tdata[31:24] >= o_m_tdata[23:16])))
        else $error("alpha below a channel");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import gccg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 110;

    typedef struct {
        logic       action;
        logic [7:0] tbl_idx;
        logic [7:0] tbl_val;
        logic [7:0] cov_r;
        logic [7:0] cov_g;
        logic [7:0] cov_b;
    } t_glyph_req;

    // first field in the low byte, as on o_m_tdata
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] third;
        logic [7:0] second;
        logic [7:0] first;
    } t_glyph_px;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 o_s_tready;
    logic [39:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 o_m_tvalid;
    logic                 m_ready = 1'b0;
    logic [31:0]          o_m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    glyph_coverage_contrast_gamma uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow of the block's configuration and gamma table
    logic        lcd_sh = 1'b0;
    logic        bgr_sh = 1'b0;
    logic [16:0] contrast_sh = '0;
    logic        gamma_sh = 1'b0;
    logic [7:0]  gamma_lut_sh [256];

    t_glyph_req pend_q[$];
    t_glyph_px  px_expect_q[$];
    int         err_cnt = 0;
    int         tx_gap_max = 0;
    int         rx_stall_pct = 0;
    bit         hold_tog = 1'b0;
    int         cycle_cnt = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] remap_cov(input logic [7:0] v);
        longint unsigned num;
        longint unsigned lift;
        longint unsigned sum;
        if (v == 8'd0 || v == 8'd255)
            return v;
        num = longint'(255 - v) * longint'(v) * longint'(contrast_sh);
        lift = (num + 64'd8355840) / 64'd16711680;
        sum = longint'(v) + lift;
        if (sum > 255)
            sum = 255;
        if (gamma_sh)
            return gamma_lut_sh[sum[7:0]];
        return sum[7:0];
    endfunction

    task automatic predict_request(input t_glyph_req rq);
        t_glyph_px  px;
        logic [7:0] tmp;
        if (rq.action == ACT_LOAD) begin
            gamma_lut_sh[rq.tbl_idx] = rq.tbl_val;
        end else if (!lcd_sh) begin
            px = '0;
            px.first = remap_cov(rq.cov_r);
            px_expect_q.push_back(px);
        end else begin
            px.first = remap_cov(rq.cov_r);
            px.second = remap_cov(rq.cov_g);
            px.third = remap_cov(rq.cov_b);
            if (bgr_sh) begin
                tmp = px.first;
                px.first = px.third;
                px.third = tmp;
            end
            px.alpha = (px.first > px.second) ? px.first : px.second;
            if (px.third > px.alpha)
                px.alpha = px.third;
            px_expect_q.push_back(px);
        end
    endtask

    // request driver: bursts of random length, random gaps between them
    t_glyph_req cur_req;
    int         burst_left = 1;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready)
                predict_request(cur_req);
            if (!s_valid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_req = pend_q.pop_front();
                    s_tdata <= {cur_req.cov_b, cur_req.cov_g, cur_req.cov_r,
                                cur_req.tbl_val, cur_req.tbl_idx};
                    s_tuser <= cur_req.action;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(24, 1);
                        gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern and long hold-off
    string     field_name [4] = '{"res_first", "res_second", "res_third", "res_alpha"};
    t_glyph_px want;
    t_glyph_px got;
    bit        hold_seen = 1'b0;
    int        hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                got = t_glyph_px'(o_m_tdata);
                if (px_expect_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end else begin
                    want = px_expect_q.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got[k*8 +: 8] !== want[k*8 +: 8]) begin
                            err_cnt++;
                            $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                                     field_name[k], want[k*8 +: 8], got[k*8 +: 8]);
                        end
                    end
                end
            end
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // wait until the pipe is empty, then let in-flight loads retire
    task automatic settle();
        @(negedge i_clk);
        while (pend_q.size() != 0 || s_valid || px_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
    endtask

    task automatic apply_config(input logic lcd, input logic bgr,
                                input logic [16:0] con, input logic gam);
        logic [CFG_DAT_W-1:0] junk;
        settle();
        // upper bits of the one-bit registers carry noise
        junk = CFG_DAT_W'($urandom);
        cfg_write(CFG_LCD_MODE, {junk[CFG_DAT_W-1:1], lcd});
        junk = CFG_DAT_W'($urandom);
        cfg_write(CFG_BGR_ORDER, {junk[CFG_DAT_W-1:1], bgr});
        cfg_write(CFG_CONTRAST, con);
        junk = CFG_DAT_W'($urandom);
        cfg_write(CFG_GAMMA_EN, {junk[CFG_DAT_W-1:1], gam});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lcd_sh = lcd;
        bgr_sh = bgr;
        contrast_sh = con;
        gamma_sh = gam;
        @(negedge i_clk);
    endtask

    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_glyph_req rq;
        rq.action = ACT_PIXEL;
        rq.tbl_idx = 8'($urandom);
        rq.tbl_val = 8'($urandom);
        rq.cov_r = r;
        rq.cov_g = g;
        rq.cov_b = b;
        pend_q.push_back(rq);
    endtask

    task automatic push_load(input logic [7:0] idx, input logic [7:0] val);
        t_glyph_req rq;
        rq.action = ACT_LOAD;
        rq.tbl_idx = idx;
        rq.tbl_val = val;
        rq.cov_r = 8'($urandom);
        rq.cov_g = 8'($urandom);
        rq.cov_b = 8'($urandom);
        pend_q.push_back(rq);
    endtask

    function automatic logic [7:0] pick_cov();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return $urandom_range(1) ? 8'd1 : 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_contrast();
        case ($urandom_range(5))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1FFFF;
            3:       return 17'($urandom_range(65536));
            default: return 17'($urandom_range(17'h1FFFF));
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: endpoints, mid values, saturation, swap, zero contrast
        tx_gap_max = 2;
        rx_stall_pct = 20;
        apply_config(1'b0, 1'b1, 17'd65536, 1'b0);
        push_pixel(8'd0, 8'($urandom), 8'($urandom));
        push_pixel(8'd255, 8'($urandom), 8'($urandom));
        push_pixel(8'd1, 8'($urandom), 8'($urandom));
        push_pixel(8'd254, 8'($urandom), 8'($urandom));
        push_pixel(8'd128, 8'($urandom), 8'($urandom));
        push_pixel(8'd64, 8'($urandom), 8'($urandom));
        apply_config(1'b1, 1'b0, 17'h1FFFF, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd1);
        push_pixel(8'd254, 8'd128, 8'd37);
        apply_config(1'b1, 1'b1, 17'h1FFFF, 1'b0);
        push_pixel(8'd0, 8'd255, 8'd1);
        push_pixel(8'd254, 8'd128, 8'd37);
        push_pixel(8'd200, 8'd3, 8'd255);
        apply_config(1'b0, 1'b0, 17'd0, 1'b0);
        push_pixel(8'd77, 8'd255, 8'd255);
        push_pixel(8'd200, 8'd0, 8'd0);

        // fill the whole gamma table before any lookup is enabled
        push_load(8'd0, 8'd255);
        push_load(8'd255, 8'd0);
        for (int i = 1; i < 255; i++)
            push_load(i[7:0], 8'($urandom));

        apply_config(1'b1, 1'b1, 17'd65536, 1'b1);
        push_pixel(8'd0, 8'd255, 8'd128);
        push_pixel(8'd1, 8'd254, 8'd100);
        push_load(8'd255, 8'd255);
        push_load(8'd0, 8'd0);
        push_pixel(8'd255, 8'd254, 8'd0);
        apply_config(1'b0, 1'b0, 17'h1FFFF, 1'b1);
        push_pixel(8'd17, 8'($urandom), 8'($urandom));
        push_pixel(8'd255, 8'($urandom), 8'($urandom));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            apply_config(1'($urandom_range(1)), 1'($urandom_range(1)), pick_contrast(),
                         1'($urandom_range(1)));
            case (ph % 4)
                0: begin
                    tx_gap_max = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_gap_max = 3;
                    rx_stall_pct = 30;
                end
                2: begin
                    tx_gap_max = 8;
                    rx_stall_pct = 60;
                end
                default: begin
                    tx_gap_max = $urandom_range(4);
                    rx_stall_pct = $urandom_range(50);
                end
            endcase
            // hold the receiver off while the sender keeps offering
            if (ph == 4 || ph == 11) begin
                tx_gap_max = 0;
                hold_tog = ~hold_tog;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(9) == 0)
                    push_load(8'($urandom), 8'($urandom));
                else
                    push_pixel(pick_cov(), pick_cov(), pick_cov());
            end
        end

        settle();
        if (err_cnt == 0 && px_expect_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ glyph_coverage_contrast_gamma.f @@
sv/gccg_pkg.sv
sv/gccg_lane.sv
sv/gccg_merge.sv
sv/glyph_coverage_contrast_gamma.sv
tb/tb_top.sv
